@@ hw/rtl/csrb_pkg.sv @@
// Shared types and constants for the contiguous-span ring buffer.
package csrb_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_DEF   = 256;
  localparam int MAX_RUN_DEF = 64;

  // Fixed field widths.
  localparam int OUT_W   = 9;
  localparam int REQ_W   = 7;
  localparam int CFG_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;

  // Register map, indexed by paddr above the byte offset.
  localparam logic [PADDR_W-3:0] REG_USED_SIZE = 1'b0;
  localparam logic [CFG_W-1:0]   USED_SIZE_RST = 9'd256;

  // Mode codes on the input stream.
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_CONSUME = 2'd1;
  localparam logic [1:0] MODE_SKIP    = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CONSUME,
    OP_SKIP,
    OP_NOP
  } csrb_op_t;

  typedef enum logic [1:0] {
    ST_DISPATCH,
    ST_SKIP2,
    ST_RUN
  } csrb_state_t;

  // One classified word waiting in the queue between front and back.
  typedef struct packed {
    csrb_op_t              op;
    logic [BYTE_W-1:0]     data;
    logic                  last;
    logic [REQ_W-1:0]      req;
  } csrb_item_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              accepted;
    logic [OUT_W-1:0]  done_count;
    logic [OUT_W-1:0]  free_span;
    logic [OUT_W-1:0]  ready_span;
    logic [OUT_W-1:0]  fill_count;
    logic              run_last;
  } csrb_result_t;

endpackage

@@ hw/rtl/csrb_ram.sv @@
// Generic single-port RAM with registered read data.
module csrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data only changes on a read, so it holds while unread.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hw/rtl/csrb_front.sv @@
// Front end: accepts input words, classifies them and queues them for the back end.
module csrb_front #(
  parameter int MAX_RUN = csrb_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [csrb_pkg::BYTE_W-1:0]    in_data,
  input  logic                           in_last,
  input  logic [csrb_pkg::REQ_W-1:0]     in_req,
  output logic                           head_valid,
  output csrb_pkg::csrb_item_t           head,
  input  logic                           pop
);

  localparam int QD  = 2;
  localparam int QIW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  csrb_pkg::csrb_item_t q [QD];
  logic [QIW-1:0]       wr_ptr;
  logic [QIW-1:0]       rd_ptr;
  logic [QCW-1:0]       count;
  csrb_pkg::csrb_item_t item;
  logic                 push;
  logic                 take;

  // Decode the mode and saturate the request length.
  always_comb begin
    item.data = in_data;
    item.last = in_last;
    if (32'(in_req) > MAX_RUN) begin
      item.req = csrb_pkg::REQ_W'(MAX_RUN);
    end else begin
      item.req = in_req;
    end
    case (in_mode)
      csrb_pkg::MODE_LOAD:    item.op = csrb_pkg::OP_LOAD;
      csrb_pkg::MODE_CONSUME: item.op = csrb_pkg::OP_CONSUME;
      csrb_pkg::MODE_SKIP:    item.op = csrb_pkg::OP_SKIP;
      default:                item.op = csrb_pkg::OP_NOP;
    endcase
  end

  assign in_ready   = (count != QCW'(QD));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign take       = pop && head_valid;

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QIW'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + QIW'(1);
      end
      if (push && !take) begin
        count <= count + QCW'(1);
      end else if (take && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

endmodule

@@ hw/rtl/csrb_back.sv @@
// Back end: executes queued words against the ring state and drives the result stream.
module csrb_back #(
  parameter int DEPTH = csrb_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_clear,
  input  logic [$clog2(DEPTH+1)-1:0]        span_size,
  input  logic                              head_valid,
  input  csrb_pkg::csrb_item_t              head,
  output logic                              pop,
  output logic                              ram_we,
  output logic                              ram_re,
  output logic [$clog2(DEPTH)-1:0]          ram_addr,
  output logic [csrb_pkg::BYTE_W-1:0]       ram_wdata,
  input  logic [csrb_pkg::BYTE_W-1:0]       ram_rdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output csrb_pkg::csrb_result_t            out_res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = csrb_pkg::REQ_W;
  localparam int MW = (CW > RW) ? CW : RW;
  localparam int OW = csrb_pkg::OUT_W;

  // Ring state.
  csrb_pkg::csrb_state_t state, state_next;
  logic [IW-1:0] write_index, write_index_next;
  logic [IW-1:0] read_index, read_index_next;
  logic [CW-1:0] held_count, held_count_next;
  logic [CW-1:0] burst_allowance, burst_allowance_next;
  logic [CW-1:0] burst_taken, burst_taken_next;
  logic          in_burst, in_burst_next;
  logic [RW-1:0] run_len, run_len_next;
  logic [RW-1:0] run_cnt, run_cnt_next;

  // Pending and output stages.
  logic                   pend_v;
  csrb_pkg::csrb_result_t pend;
  logic                   pend_sel;
  logic                   pend_move;
  logic                   can_issue;

  // Decisions for the current cycle.
  logic [CW-1:0] free_cur, ready_cur;
  logic [MW-1:0] take_first;
  logic [MW-1:0] take_second;
  logic          run_last_step;
  logic          issue;
  logic          res_acc;
  logic          res_sel;
  logic          res_last;
  logic [OW-1:0] res_done;
  logic [CW-1:0] free_after, ready_after;
  logic [CW-1:0] allow;
  logic [CW-1:0] taken;
  logic [RW-1:0] left;

  function automatic logic [CW-1:0] free_of(input logic [IW-1:0] wi, input logic [IW-1:0] ri,
                                            input logic [CW-1:0] held, input logic [CW-1:0] sz);
    logic [CW-1:0] r;
    if (wi == ri) begin
      r = (held != '0) ? '0 : sz - CW'(wi);
    end else if (wi > ri) begin
      r = sz - CW'(wi);
    end else begin
      r = CW'(ri) - CW'(wi);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] ready_of(input logic [IW-1:0] wi, input logic [IW-1:0] ri,
                                             input logic [CW-1:0] held, input logic [CW-1:0] sz);
    logic [CW-1:0] r;
    if (wi == ri) begin
      r = (held != '0) ? sz - CW'(ri) : '0;
    end else if (wi > ri) begin
      r = CW'(wi) - CW'(ri);
    end else begin
      r = sz - CW'(ri);
    end
    return r;
  endfunction

  // Index advance that wraps to zero at the end of the used span.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] idx, input logic [CW-1:0] amt,
                                             input logic [CW-1:0] sz);
    logic [CW-1:0] sum;
    sum = CW'(idx) + amt;
    return (sum >= sz) ? '0 : sum[IW-1:0];
  endfunction

  // Spans of the current state and the clamped transfer lengths.
  always_comb begin
    free_cur  = free_of(write_index, read_index, held_count, span_size);
    ready_cur = ready_of(write_index, read_index, held_count, span_size);
    if (MW'(ready_cur) < MW'(head.req)) begin
      take_first = MW'(ready_cur);
    end else begin
      take_first = MW'(head.req);
    end
    if (MW'(ready_cur) < MW'(run_len)) begin
      take_second = MW'(ready_cur);
    end else begin
      take_second = MW'(run_len);
    end
    run_last_step = ((run_cnt + RW'(1)) == run_len);
  end

  assign pend_move = pend_v && (!out_valid || out_ready);
  assign can_issue = !pend_v || pend_move;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      csrb_pkg::ST_DISPATCH: begin
        if (head_valid && head.op == csrb_pkg::OP_CONSUME && take_first != '0) begin
          state_next = csrb_pkg::ST_RUN;
        end else if (head_valid && head.op == csrb_pkg::OP_SKIP) begin
          state_next = csrb_pkg::ST_SKIP2;
        end
      end
      csrb_pkg::ST_SKIP2: begin
        if (can_issue) begin
          state_next = csrb_pkg::ST_DISPATCH;
        end
      end
      csrb_pkg::ST_RUN: begin
        if (can_issue && run_last_step) begin
          state_next = csrb_pkg::ST_DISPATCH;
        end
      end
      default: state_next = csrb_pkg::ST_DISPATCH;
    endcase
  end

  // Actions of the sequencer: ring updates, store access and result issue.
  always_comb begin
    write_index_next     = write_index;
    read_index_next      = read_index;
    held_count_next      = held_count;
    burst_allowance_next = burst_allowance;
    burst_taken_next     = burst_taken;
    in_burst_next        = in_burst;
    run_len_next         = run_len;
    run_cnt_next         = run_cnt;
    pop       = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = write_index;
    ram_wdata = head.data;
    res_acc   = 1'b0;
    res_sel   = 1'b0;
    res_last  = 1'b1;
    res_done  = '0;
    allow     = '0;
    taken     = '0;
    left      = '0;
    case (state)
      csrb_pkg::ST_DISPATCH: begin
        if (head_valid) begin
          case (head.op)
            csrb_pkg::OP_LOAD: begin
              if (can_issue) begin
                // The first byte of a burst samples the contiguous free span.
                allow = in_burst ? burst_allowance : free_cur;
                taken = in_burst ? burst_taken : '0;
                if (taken < allow) begin
                  ram_we           = 1'b1;
                  write_index_next = wrap_add(write_index, CW'(1), span_size);
                  held_count_next  = held_count + CW'(1);
                  taken            = taken + CW'(1);
                  res_acc          = 1'b1;
                end
                burst_allowance_next = allow;
                burst_taken_next     = taken;
                in_burst_next        = !head.last;
                res_done             = OW'(taken);
                pop   = 1'b1;
                issue = 1'b1;
              end
            end
            csrb_pkg::OP_CONSUME: begin
              if (take_first == '0) begin
                if (can_issue) begin
                  pop   = 1'b1;
                  issue = 1'b1;
                end
              end else begin
                run_len_next = RW'(take_first);
                run_cnt_next = '0;
              end
            end
            csrb_pkg::OP_SKIP: begin
              // First pass: up to the end of the readable span.
              read_index_next = wrap_add(read_index, CW'(take_first), span_size);
              held_count_next = held_count - CW'(take_first);
              run_len_next    = head.req - RW'(take_first);
            end
            default: begin
              if (can_issue) begin
                pop   = 1'b1;
                issue = 1'b1;
              end
            end
          endcase
        end
      end
      csrb_pkg::ST_SKIP2: begin
        // Second pass after a possible wrap, then report the total.
        if (can_issue) begin
          read_index_next = wrap_add(read_index, CW'(take_second), span_size);
          held_count_next = held_count - CW'(take_second);
          left     = run_len - RW'(take_second);
          res_done = OW'(head.req - left);
          pop      = 1'b1;
          issue    = 1'b1;
        end
      end
      csrb_pkg::ST_RUN: begin
        // One byte a cycle from the single store port, while the pending stage can take a word.
        if (can_issue) begin
          ram_re          = 1'b1;
          ram_addr        = read_index;
          read_index_next = wrap_add(read_index, CW'(1), span_size);
          held_count_next = held_count - CW'(1);
          run_cnt_next    = run_cnt + RW'(1);
          res_sel         = 1'b1;
          res_done        = OW'(run_cnt + RW'(1));
          res_last        = run_last_step;
          pop             = run_last_step;
          issue           = 1'b1;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Status reported with each result reflects the state after its action.
  assign free_after  = free_of(write_index_next, read_index_next, held_count_next, span_size);
  assign ready_after = ready_of(write_index_next, read_index_next, held_count_next, span_size);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      state           <= csrb_pkg::ST_DISPATCH;
      write_index     <= '0;
      read_index      <= '0;
      held_count      <= '0;
      burst_allowance <= '0;
      burst_taken     <= '0;
      in_burst        <= 1'b0;
      run_len         <= '0;
      run_cnt         <= '0;
    end else begin
      state           <= state_next;
      write_index     <= write_index_next;
      read_index      <= read_index_next;
      held_count      <= held_count_next;
      burst_allowance <= burst_allowance_next;
      burst_taken     <= burst_taken_next;
      in_burst        <= in_burst_next;
      run_len         <= run_len_next;
      run_cnt         <= run_cnt_next;
    end
  end

  // Valid flags of the pending and output stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        pend_v <= 1'b1;
      end else if (pend_move) begin
        pend_v <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payloads; the store byte joins when the word leaves the pending stage.
  always_ff @(posedge clk) begin
    if (issue) begin
      pend.out_byte   <= '0;
      pend.accepted   <= res_acc;
      pend.done_count <= res_done;
      pend.free_span  <= OW'(free_after);
      pend.ready_span <= OW'(ready_after);
      pend.fill_count <= OW'(held_count_next);
      pend.run_last   <= res_last;
      pend_sel        <= res_sel;
    end
    if (pend_move) begin
      out_res.out_byte   <= pend_sel ? ram_rdata : pend.out_byte;
      out_res.accepted   <= pend.accepted;
      out_res.done_count <= pend.done_count;
      out_res.free_span  <= pend.free_span;
      out_res.ready_span <= pend.ready_span;
      out_res.fill_count <= pend.fill_count;
      out_res.run_last   <= pend.run_last;
    end
  end

endmodule

@@ hw/rtl/contiguous_span_ring_buffer_unit.sv @@
// Top level of the contiguous-span ring buffer: stream ports, register port and wiring.
// With a free output a result word passes the queue, pending and output registers for a load,
// a no-op or an empty consume, plus the second-pass state for a skip or the run state for the
// first byte of a consume run. Loads and no-ops go one per cycle while the output is free.
// Reset is synchronous and clears the indices, fill count, burst state, queue and outputs;
// store contents stay undefined. A used_size write empties the ring but not queue or outputs.
module contiguous_span_ring_buffer_unit #(
  parameter int DEPTH   = csrb_pkg::DEPTH_DEF,
  parameter int MAX_RUN = csrb_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream. s_tdata: data_byte[7:0], request_length[14:8], zero[15]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,
  input  logic [1:0]                    s_tuser,   // mode[1:0]
  input  logic                          s_tlast,
  // Result stream. m_tdata: out_byte[7:0], accepted[8], done_count[17:9],
  // free_span[26:18], ready_span[35:27], fill_count[44:36], zero[47:45]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,
  output logic                          m_tlast,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csrb_pkg::PADDR_W-1:0]  paddr,
  input  logic [csrb_pkg::DATA_W-1:0]   pwdata,
  output logic [csrb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [csrb_pkg::CFG_W-1:0]  used_size;
  logic [CW-1:0]               span_size;
  logic                        reg_hit;
  logic                        cfg_clear;
  logic                        head_valid;
  csrb_pkg::csrb_item_t        head;
  logic                        pop;
  logic                        ram_we;
  logic                        ram_re;
  logic [IW-1:0]               ram_addr;
  logic [csrb_pkg::BYTE_W-1:0] ram_wdata;
  logic [csrb_pkg::BYTE_W-1:0] ram_rdata;
  csrb_pkg::csrb_result_t      res;

  // Register port: one register, writes empty the buffer.
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[csrb_pkg::PADDR_W-1:2] == csrb_pkg::REG_USED_SIZE);
  assign cfg_clear = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? csrb_pkg::DATA_W'(used_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= csrb_pkg::USED_SIZE_RST;
    end else if (cfg_clear) begin
      used_size <= pwdata[csrb_pkg::CFG_W-1:0];
    end
  end

  // Effective span: zero acts as one, and anything above the store acts as its depth.
  always_comb begin
    if (used_size == '0) begin
      span_size = CW'(1);
    end else if (32'(used_size) > DEPTH) begin
      span_size = CW'(DEPTH);
    end else begin
      span_size = CW'(used_size);
    end
  end

  csrb_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (s_tuser),
    .in_data    (s_tdata[7:0]),
    .in_last    (s_tlast),
    .in_req     (s_tdata[14:8]),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  csrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_clear),
    .span_size  (span_size),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res)
  );

  csrb_ram #(
    .WIDTH (csrb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Pack the result word.
  assign m_tdata = {3'b000, res.fill_count, res.ready_span, res.free_span,
                    res.done_count, res.accepted, res.out_byte};
  assign m_tlast = res.run_last;

endmodule

@@ hw/rtl/csrb_checker.sv @@
// Port-level checks for the contiguous-span ring buffer, bound to the top level.
module csrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // A stored load byte is a single-word result with a nonzero burst count and no data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tlast && m_tdata[17:9] != 9'd0 && m_tdata[7:0] == 8'd0)
    else $error("malformed load result");

  // Only a consume run has words before its last, each counting a byte.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[8] && m_tdata[17:9] != 9'd0)
    else $error("malformed consume run word");

  // Reset empties the result stage.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind contiguous_span_ring_buffer_unit csrb_checker u_csrb_checker (.*);
